[hw/rtl/tct_pkg.sv]
// tct_pkg: beat types, register indexes and fixed constants of the
// threshold centroid tracker. No dependencies.
`default_nettype none

package tct_pkg;

    localparam int BRIGHT_W      = 8;
    localparam int FRAME_WIDTH_W = 11;
    localparam int COORD_W       = 10;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = FRAME_WIDTH_W;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [BRIGHT_W-1:0]      THRESHOLD_RESET   = 8'd240;
    localparam logic [FRAME_WIDTH_W-1:0] FRAME_WIDTH_RESET = 11'd640;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 4'd1;

    typedef struct packed {
        logic [BRIGHT_W-1:0] brightness;
        logic                last_pixel;
    } t_in_beat;

    typedef struct packed {
        logic               pixel_on;
        logic               frame_done;
        logic               cog_found;
        logic [COORD_W-1:0] cog_x;
        logic [COORD_W-1:0] cog_y;
    } t_out_beat;

endpackage

`default_nettype wire

[hw/rtl/threshold_centroid_tracker_top.sv]
// threshold_centroid_tracker_top: configuration registers and the
// front / queue / back split. Depends on tct_pkg, tct_front, tct_queue, tct_back.
//
// Binary threshold and centre of gravity of a raster pixel stream. Each
// input beat is one pixel brightness with a last-pixel flag; each output
// beat carries pixel_on (brightness >= threshold) and, on the last pixel
// of a frame, frame_done plus the centroid rounded half up, or cog_found
// clear and 0,0 when no pixel was lit. Column/row counters wrap at the
// configured frame width (0 acts as 1, beyond MAX_WIDTH as MAX_WIDTH) and
// at MAX_HEIGHT rows. Rate: one pixel per cycle within a frame while the
// job queue has room; a pixel beat is registered in the job queue and
// then in the output register before its result beat is valid. The last
// pixel of a frame with any lit pixel starts two bit-serial dividers side
// by side, one quotient bit per cycle, SXW+1 quotient bits for x, where
// SXW = clog2(MAX_WIDTH*MAX_HEIGHT+1) + clog2(MAX_WIDTH), i.e. 31 at the
// defaults. The back starts the dividers, waits for both to finish and
// then loads the result into the output register. Meanwhile the
// four-entry job queue keeps taking pixels and then the input stalls
// until the back pops again. A frame end with nothing lit does not start
// the dividers and adds no stall. Output back-pressure adds its own
// stalls. Config writes are always taken (o_cfg_ready is tied high) and
// apply from the next pixel; write them while the block is idle.

`default_nettype none

module threshold_centroid_tracker_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // pixel beats in
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  tct_pkg::t_in_beat                  i_in_data,
    // result beats out
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output tct_pkg::t_out_beat                 o_out_data,
    // register writes
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [tct_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [tct_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tct_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int EW    = $clog2(MAX_WIDTH + 1);
    localparam int CNTW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int SXW   = CNTW + CW;
    localparam int SYW   = CNTW + RW;
    localparam int JOB_W = 2 + CNTW + SXW + SYW;
    // common width for clamping the frame width register
    localparam int CMPW  = (EW > FRAME_WIDTH_W) ? EW : FRAME_WIDTH_W;

    logic [BRIGHT_W-1:0]      r_threshold;
    logic [FRAME_WIDTH_W-1:0] r_frame_width;
    logic [EW-1:0]            w_eff_width;

    logic                     w_push, w_full, w_job_valid, w_pop;
    logic [JOB_W-1:0]         w_job_in, w_job_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= THRESHOLD_RESET;
            r_frame_width <= FRAME_WIDTH_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_THRESHOLD:   r_threshold   <= i_cfg_data[BRIGHT_W-1:0];
                REG_FRAME_WIDTH: r_frame_width <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // clamp to 1..MAX_WIDTH
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff_width = EW'(1);
        end else if (CMPW'(r_frame_width) > CMPW'(MAX_WIDTH)) begin
            w_eff_width = EW'(MAX_WIDTH);
        end else begin
            w_eff_width = EW'(r_frame_width);
        end
    end

    tct_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_threshold (r_threshold),
        .i_eff_width (w_eff_width),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_job       (w_job_in)
    );

    tct_queue #(.W(JOB_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .o_full  (w_full),
        .o_valid (w_job_valid),
        .o_data  (w_job_out),
        .i_pop   (w_pop)
    );

    tct_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job_out),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

[hw/rtl/tct_front.sv]
// tct_front: thresholds each pixel, tracks column/row and accumulates sums.
// Pushes one job per pixel into the queue. Depends on tct_pkg.
`default_nettype none

module tct_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int CW    = $clog2(MAX_WIDTH),
    parameter int RW    = $clog2(MAX_HEIGHT),
    parameter int EW    = $clog2(MAX_WIDTH + 1),
    parameter int CNTW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
    parameter int SXW   = CNTW + CW,
    parameter int SYW   = CNTW + RW,
    parameter int JOB_W = 2 + CNTW + SXW + SYW
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  tct_pkg::t_in_beat               i_in_data,
    input  wire [tct_pkg::BRIGHT_W-1:0]     i_threshold,
    input  wire [EW-1:0]                    i_eff_width,
    input  wire                             i_full,
    output logic                            o_push,
    output logic [JOB_W-1:0]                o_job
);
    import tct_pkg::*;

    localparam logic [CNTW-1:0] CAP = CNTW'(MAX_WIDTH * MAX_HEIGHT);

    logic [CW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic [SXW-1:0]  r_sx, n_sx;
    logic [SYW-1:0]  r_sy, n_sy;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            w_on, w_acc, w_accept, w_col_wrap, w_row_wrap;

    always_comb begin
        w_on       = i_in_data.brightness >= i_threshold;
        w_acc      = w_on && (r_cnt < CAP);
        n_sx       = r_sx + (w_acc ? SXW'(r_col) : SXW'(0));
        n_sy       = r_sy + (w_acc ? SYW'(r_row) : SYW'(0));
        n_cnt      = r_cnt + CNTW'(w_acc);
        w_col_wrap = ((EW+1)'(r_col) + (EW+1)'(1)) >= (EW+1)'(i_eff_width);
        w_row_wrap = ((RW+1)'(r_row) + (RW+1)'(1)) >= (RW+1)'(MAX_HEIGHT);
        w_accept   = i_in_valid && !i_full;
    end

    assign o_in_ready = !i_full;
    assign o_push     = w_accept;
    assign o_job      = {w_on, i_in_data.last_pixel, n_cnt, n_sy, n_sx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_cnt <= '0;
        end else if (w_accept) begin
            if (i_in_data.last_pixel) begin
                r_col <= '0;
                r_row <= '0;
                r_sx  <= '0;
                r_sy  <= '0;
                r_cnt <= '0;
            end else begin
                r_sx  <= n_sx;
                r_sy  <= n_sy;
                r_cnt <= n_cnt;
                if (w_col_wrap) begin
                    r_col <= '0;
                    r_row <= w_row_wrap ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tct_queue.sv]
// tct_queue: small FIFO of jobs between front and back.
// Depends on tct_pkg for its depth.
`default_nettype none

module tct_queue #(
    parameter int W = 8
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_push,
    input  wire [W-1:0]  i_data,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  wire          i_pop
);
    import tct_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [W-1:0]  r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_fill;

    assign o_full  = r_fill == (PW+1)'(QUEUE_DEPTH);
    assign o_valid = r_fill != '0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + (PW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - (PW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tct_div.sv]
// tct_div: restoring divider, one quotient bit per cycle.
// No dependencies beyond tct_pkg conventions.
`default_nettype none

module tct_div #(
    parameter int NW = 32,
    parameter int DW = 22
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_start,
    input  wire  [NW-1:0] i_num,
    input  wire  [DW-1:0] i_den,
    output logic          o_busy,
    output logic [NW-1:0] o_quot
);
    import tct_pkg::*;

    localparam int KW = $clog2(NW + 1);

    logic [NW-1:0] r_num;
    logic [DW-1:0] r_rem, r_den, n_rem;
    logic [KW-1:0] r_left;
    logic          r_busy, w_bit;
    logic [DW:0]   w_trial, w_diff;

    always_comb begin
        w_trial = {r_rem, r_num[NW-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_bit   = !w_diff[DW];
        n_rem   = w_bit ? w_diff[DW-1:0] : w_trial[DW-1:0];
    end

    assign o_busy = r_busy;
    assign o_quot = r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_left <= KW'(NW);
        end else if (r_busy) begin
            r_left <= r_left - KW'(1);
            if (r_left == KW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], w_bit};
            r_rem <= n_rem;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tct_back.sv]
// tct_back: drains jobs, runs the per-frame divisions and holds the output
// register. Depends on tct_pkg and tct_div.
`default_nettype none

module tct_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int CW    = $clog2(MAX_WIDTH),
    parameter int RW    = $clog2(MAX_HEIGHT),
    parameter int CNTW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
    parameter int SXW   = CNTW + CW,
    parameter int SYW   = CNTW + RW,
    parameter int JOB_W = 2 + CNTW + SXW + SYW
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_job_valid,
    input  wire [JOB_W-1:0]     i_job,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output tct_pkg::t_out_beat  o_out_data
);
    import tct_pkg::*;

    localparam int NXW = SXW + 1;
    localparam int NYW = SYW + 1;
    localparam int DW  = CNTW + 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic            r_state;
    logic            r_pix_on;
    logic            r_out_valid;
    t_out_beat       r_out;

    logic [SXW-1:0]  w_sx;
    logic [SYW-1:0]  w_sy;
    logic [CNTW-1:0] w_cnt;
    logic            w_last, w_on, w_slot_free, w_start, w_load;
    logic            w_busy_x, w_busy_y;
    logic [NXW-1:0]  w_num_x, w_qx;
    logic [NYW-1:0]  w_num_y, w_qy;
    logic [DW-1:0]   w_den;
    t_out_beat       w_beat;

    always_comb begin
        w_sx        = i_job[SXW-1:0];
        w_sy        = i_job[SXW+SYW-1:SXW];
        w_cnt       = i_job[SXW+SYW+CNTW-1:SXW+SYW];
        w_last      = i_job[SXW+SYW+CNTW];
        w_on        = i_job[SXW+SYW+CNTW+1];
        // round half up: (2*sum + count) / (2*count)
        w_num_x     = {w_sx, 1'b0} + NXW'(w_cnt);
        w_num_y     = {w_sy, 1'b0} + NYW'(w_cnt);
        w_den       = {w_cnt, 1'b0};
        w_slot_free = !r_out_valid || i_out_ready;

        o_pop   = 1'b0;
        w_start = 1'b0;
        w_load  = 1'b0;
        w_beat  = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    if (w_last && w_cnt != '0) begin
                        o_pop   = 1'b1;
                        w_start = 1'b1;
                    end else if (w_slot_free) begin
                        o_pop             = 1'b1;
                        w_load            = 1'b1;
                        w_beat.pixel_on   = w_on;
                        w_beat.frame_done = w_last;
                    end
                end
            end
            ST_DIV: begin
                if (!w_busy_x && !w_busy_y && w_slot_free) begin
                    w_load            = 1'b1;
                    w_beat.pixel_on   = r_pix_on;
                    w_beat.frame_done = 1'b1;
                    w_beat.cog_found  = 1'b1;
                    w_beat.cog_x      = COORD_W'(w_qx);
                    w_beat.cog_y      = COORD_W'(w_qy);
                end
            end
            default: begin
            end
        endcase
    end

    tct_div #(.NW(NXW), .DW(DW)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num_x),
        .i_den   (w_den),
        .o_busy  (w_busy_x),
        .o_quot  (w_qx)
    );

    tct_div #(.NW(NYW), .DW(DW)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num_y),
        .i_den   (w_den),
        .o_busy  (w_busy_y),
        .o_quot  (w_qy)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_start) begin
                r_state <= ST_DIV;
            end else if (w_load) begin
                r_state <= ST_IDLE;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_pix_on <= w_on;
        end
        if (w_load) begin
            r_out <= w_beat;
        end
    end

endmodule

`default_nettype wire

[tb/threshold_centroid_tracker_top_tb.sv]
// threshold_centroid_tracker_top_tb: self-checking bench for the threshold
// centroid tracker. Depends on tct_pkg and threshold_centroid_tracker_top.
// Directed frames first, then random frames under random back-pressure.

module threshold_centroid_tracker_top_tb;

    import tct_pkg::*;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 1024;
    localparam int LIT_CAP       = MAX_W * MAX_H;
    // idle wait at the end of the run, once all results have drained
    localparam int DRAIN_CYCLES  = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PIXELS = 150;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    t_in_beat               in_data;
    logic                   out_valid;
    logic                   out_ready;
    t_out_beat              out_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // no random idling on either side while set
    logic                   calm = 1'b0;

    // predictor copy of registers and frame accumulators
    logic [BRIGHT_W-1:0]      thr_reg;
    logic [FRAME_WIDTH_W-1:0] fw_reg;
    logic [COORD_W-1:0]       col_cnt;
    logic [COORD_W-1:0]       row_cnt;
    logic [29:0]              col_sum;
    logic [29:0]              row_sum;
    logic [20:0]              lit_cnt;

    t_out_beat expected_beats[$];
    t_out_beat want;
    int        err_count   = 0;
    int        stall_count = 0;

    threshold_centroid_tracker_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Round half up of sum / count; count is never zero here.
    function automatic logic [COORD_W-1:0] rounded_mean(input longint unsigned total,
                                                         input longint unsigned count);
        longint unsigned q;
        q = (2 * total + count) / (2 * count);
        return q[COORD_W-1:0];
    endfunction

    function automatic void clear_frame();
        col_cnt = '0;
        row_cnt = '0;
        col_sum = '0;
        row_sum = '0;
        lit_cnt = '0;
    endfunction

    // Expected result beat for one pixel; advances the frame accumulators.
    function automatic t_out_beat predict_pixel(input t_in_beat px);
        t_out_beat   r;
        int unsigned w;
        logic        lit;
        w = fw_reg;
        if (w < 1) w = 1;
        if (w > MAX_W) w = MAX_W;
        lit = (px.brightness >= thr_reg);
        // past the cap, lit pixels are flagged but no longer summed
        if (lit && lit_cnt < LIT_CAP) begin
            col_sum += col_cnt;
            row_sum += row_cnt;
            lit_cnt += 1;
        end
        r = '0;
        r.pixel_on = lit;
        if (px.last_pixel) begin
            r.frame_done = 1'b1;
            if (lit_cnt != 0) begin
                r.cog_found = 1'b1;
                r.cog_x     = rounded_mean(col_sum, lit_cnt);
                r.cog_y     = rounded_mean(row_sum, lit_cnt);
            end
            clear_frame();
        end else if (col_cnt + 1 >= w) begin
            // also covers a width lowered below the current column
            col_cnt = '0;
            if (row_cnt + 1 >= MAX_H) row_cnt = '0;
            else row_cnt = row_cnt + 1'b1;
        end else begin
            col_cnt = col_cnt + 1'b1;
        end
        return r;
    endfunction

    // Receiver: random back-pressure, changed on the falling edge.
    always @(negedge clk) begin
        out_ready <= calm || ($urandom_range(0, 99) >= 14);
    end

    // Everything sampled at the rising edge: register writes, accepted pixel
    // beats (predicted), accepted result beats (checked), and the watchdog.
    always @(posedge clk) begin
        if (!rst_n) begin
            thr_reg = THRESHOLD_RESET;
            fw_reg  = FRAME_WIDTH_RESET;
            clear_frame();
            stall_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_THRESHOLD:   thr_reg = cfg_data[BRIGHT_W-1:0];
                    REG_FRAME_WIDTH: fw_reg  = cfg_data;
                    default: ;  // unused index, no effect
                endcase
            end
            if (in_valid && in_ready)
                expected_beats.push_back(predict_pixel(in_data));
            if (out_valid && out_ready) begin
                if (expected_beats.size() == 0) begin
                    $error("result beat with nothing expected");
                    err_count++;
                end else begin
                    want = expected_beats.pop_front();
                    if (out_data.pixel_on !== want.pixel_on) begin
                        $error("pixel_on: expected %0d, actual %0d",
                               want.pixel_on, out_data.pixel_on);
                        err_count++;
                    end
                    if (out_data.frame_done !== want.frame_done) begin
                        $error("frame_done: expected %0d, actual %0d",
                               want.frame_done, out_data.frame_done);
                        err_count++;
                    end
                    if (out_data.cog_found !== want.cog_found) begin
                        $error("cog_found: expected %0d, actual %0d",
                               want.cog_found, out_data.cog_found);
                        err_count++;
                    end
                    if (out_data.cog_x !== want.cog_x) begin
                        $error("cog_x: expected %0d, actual %0d",
                               want.cog_x, out_data.cog_x);
                        err_count++;
                    end
                    if (out_data.cog_y !== want.cog_y) begin
                        $error("cog_y: expected %0d, actual %0d",
                               want.cog_y, out_data.cog_y);
                        err_count++;
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready)
                    || (cfg_valid && cfg_ready))
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= STALL_LIMIT) begin
                $display("threshold_centroid_tracker_top: mismatch");
                $finish;
            end
        end
    end

    // All tasks are entered and left on a falling edge. A pixel beat left
    // pending by send_pixel is either replaced or dropped by the next caller.
    task automatic send_pixel(input logic [BRIGHT_W-1:0] level, input logic last);
        t_in_beat beat;
        while (!calm && $urandom_range(0, 99) < 14) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        beat.brightness = level;
        beat.last_pixel = last;
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Stop sending and wait until every expected result beat has arrived.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(negedge clk);
    endtask

    // Register write, only ever on an idle block.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Long dark frame with up to two pixels at full brightness (threshold 255).
    task automatic send_sparse_frame(input int len, input int lit_a, input int lit_b);
        for (int i = 0; i < len; i++) begin
            send_pixel((i == lit_a || i == lit_b) ? 8'd255 : 8'($urandom_range(0, 254)),
                       i == len - 1);
        end
    endtask

    // Levels clustered around the threshold, at the rails, or anywhere.
    function automatic logic [BRIGHT_W-1:0] pick_level(input logic [BRIGHT_W-1:0] thr);
        int v;
        case ($urandom_range(0, 3))
            1: begin
                v = int'(thr) + int'($urandom_range(0, 4)) - 2;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                return 8'(v);
            end
            2: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Reset values: threshold 240, width 640.
    task automatic test_reset_registers();
        send_pixel(8'd239, 1'b0);
        send_pixel(8'd240, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0,   1'b0);
        send_pixel(8'd100, 1'b1);   // lit at columns 1 and 2: x rounds up to 2
        send_pixel(8'd239, 1'b0);
        send_pixel(8'd0,   1'b0);
        send_pixel(8'd17,  1'b1);   // nothing lit
        send_pixel(8'd255, 1'b1);   // one-pixel frame
    endtask

    task automatic test_threshold_extremes();
        write_reg(REG_THRESHOLD, 11'h700);  // threshold 0, unused upper bits set
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd0, 1'b1);
        write_reg(REG_THRESHOLD, 11'h0FF);
        send_pixel(8'd254, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b1);
    endtask

    // Width 0 behaves as 1: every pixel starts a new row.
    task automatic test_zero_width();
        write_reg(REG_THRESHOLD, 11'd0);
        write_reg(REG_FRAME_WIDTH, 11'd0);
        for (int i = 0; i < 4; i++) send_pixel(8'($urandom_range(0, 255)), i == 3);
    endtask

    // Column already past the new width wraps on the following pixel.
    task automatic test_width_lowered_mid_row();
        write_reg(REG_THRESHOLD, 11'd128);
        write_reg(REG_FRAME_WIDTH, 11'd8);
        for (int i = 0; i < 6; i++) send_pixel(8'd200, 1'b0);
        send_pixel(8'd127, 1'b0);
        write_reg(REG_FRAME_WIDTH, 11'd3);
        send_pixel(8'd200, 1'b0);
        send_pixel(8'd200, 1'b0);
        send_pixel(8'd128, 1'b1);
    endtask

    // Writes to indexes past the register list leave both registers alone.
    task automatic test_unused_indexes();
        for (int idx = REG_FRAME_WIDTH + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom_range(0, 2047)));
        send_pixel(8'd127, 1'b0);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd255, 1'b1);
    endtask

    // Widths above the maximum clamp to it: lit at the far column of row 0,
    // and the pixel after it opens row 1 at column 0.
    task automatic test_wide_frames();
        write_reg(REG_THRESHOLD, 11'd255);
        write_reg(REG_FRAME_WIDTH, 11'd2047);
        send_sparse_frame(MAX_W + 1, MAX_W - 1, MAX_W);
    endtask

    // Random settings per phase, mostly short frames, some early frame ends.
    task automatic test_random_frames();
        int                       phase;
        int                       sent;
        int                       frames;
        int                       len;
        logic [BRIGHT_W-1:0]      thr;
        logic [FRAME_WIDTH_W-1:0] width;
        logic                     last;
        phase = 0;
        sent  = 0;
        while (sent < RANDOM_PIXELS) begin
            case (phase)
                1: thr = 8'd0;
                2: thr = 8'd255;
                default: thr = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 9))
                0: width = 11'd0;
                1: width = 11'd1024;
                2: width = 11'($urandom_range(1025, 2047));
                3: width = 11'd1;
                default: width = 11'($urandom_range(2, 24));
            endcase
            write_reg(REG_THRESHOLD, {3'($urandom_range(0, 7)), thr});
            write_reg(REG_FRAME_WIDTH, width);
            calm = (phase == 0);    // first phase runs without any idling
            frames = $urandom_range(3, 8);
            for (int f = 0; f < frames; f++) begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(41, 200)
                                                   : $urandom_range(1, 40);
                for (int i = 0; i < len; i++) begin
                    last = (i == len - 1) || ($urandom_range(0, 59) == 0);
                    send_pixel(pick_level(thr), last);
                    // hold the sender until the pipeline is empty, mid-frame
                    if (i == len / 2 && ((phase == 0 && f == 0)
                                         || $urandom_range(0, 19) == 0))
                        drain_results();
                end
                sent += len;
            end
            phase++;
        end
        calm = 1'b0;
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_registers();
        test_threshold_extremes();
        test_zero_width();
        test_width_lowered_mid_row();
        test_unused_indexes();
        test_wide_frames();
        test_random_frames();

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (err_count == 0)
            $display("threshold_centroid_tracker_top: match");
        else
            $display("threshold_centroid_tracker_top: mismatch");
        $finish;
    end

endmodule

[files.f]
hw/rtl/tct_pkg.sv
hw/rtl/tct_front.sv
hw/rtl/tct_queue.sv
hw/rtl/tct_div.sv
hw/rtl/tct_back.sv
hw/rtl/threshold_centroid_tracker_top.sv
tb/threshold_centroid_tracker_top_tb.sv
